### hdl/quaternary_min_heap_with_handles_defines.svh
// Assertion macros used by the heap controller.
// No dependencies; included by files that carry assertions.
`ifndef QUATERNARY_MIN_HEAP_WITH_HANDLES_DEFINES_SVH
`define QUATERNARY_MIN_HEAP_WITH_HANDLES_DEFINES_SVH

// same-cycle implication
`define QMH_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define QMH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/qmh_pkg.sv
// Package for the 4-ary min-heap: defaults, codes, state type and
// controller/datapath command and status structs. No dependencies.
package qmh_pkg;

    localparam int CAPACITY_DEF  = 256;
    localparam int HANDLES_DEF   = 256;
    localparam int KEY_WIDTH_DEF = 64;

    localparam logic [1:0] FN_INSERT  = 2'd0;
    localparam logic [1:0] FN_EXTRACT = 2'd1;
    localparam logic [1:0] FN_DELETE  = 2'd2;
    localparam logic [1:0] FN_PEEK    = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_ABSENT = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOOKUP,
        S_CHK,
        S_MOVE,
        S_SU_LOAD,
        S_SU_LATCH,
        S_SU_CHK,
        S_SU_CMP,
        S_SD_LOAD,
        S_SD_LATCH,
        S_SD_CHK,
        S_SD_SCAN,
        S_SD_DEC,
        S_FINISH
    } state_t;

    typedef enum logic [2:0] {
        RD_ZERO,
        RD_BASE,
        RD_LAST,
        RD_PARENT,
        RD_CHILD0,
        RD_NEXT
    } rsel_t;

    typedef enum logic [2:0] {
        W_NONE,
        W_IN_POS,
        W_IN_CNT,
        W_RD_BASE,
        W_RD_HOLE,
        W_MV_HOLE,
        W_BEST_HOLE
    } wsel_t;

    typedef enum logic [1:0] {
        CLR_NONE,
        CLR_IN,
        CLR_RD
    } clr_t;

    typedef enum logic [1:0] {
        BASE_KEEP,
        BASE_POS,
        BASE_CNT,
        BASE_ZERO
    } base_t;

    typedef struct packed {
        rsel_t       rsel;
        wsel_t       wsel;
        clr_t        clr;
        base_t       base_sel;
        logic        cnt_inc;
        logic        cnt_dec;
        logic        mv_load;
        logic        hole_par;
        logic        hole_best;
        logic        scan_start;
        logic        scan_step;
        logic        res_root;
        logic        set_st;
        logic [1:0]  st;
        logic        commit;
    } cmd_t;

    typedef struct packed {
        logic [1:0] func;
        logic       present;
        logic       h_oor;
        logic       empty;
        logic       full;
        logic       cnt_gt1;
        logic       pos_last;
        logic       hole_zero;
        logic       par_less;
        logic       first_ge;
        logic       scan_more;
        logic       best_less;
    } sts_t;

endpackage

### hdl/qmh_if.sv
// Valid/ready channel interfaces for heap requests and responses.
// No dependencies.
interface qmh_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [7:0]  handle;
    logic [63:0] key;

    modport source (output valid, output func, output handle, output key, input ready);
    modport sink (input valid, input func, input handle, input key, output ready);
endinterface

interface qmh_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  out_handle;
    logic [63:0] out_key;
    logic [8:0]  count;

    modport source (output valid, output status, output out_handle, output out_key,
                    output count, input ready);
    modport sink (input valid, input status, input out_handle, input out_key,
                  input count, output ready);
endinterface

### hdl/qmh_datapath.sv
// Heap datapath: slot and position memories, sift registers, result registers.
// Depends on qmh_pkg; driven by qmh_ctrl through cmd_t, reports through sts_t.
module qmh_datapath #(
    parameter int CAPACITY  = qmh_pkg::CAPACITY_DEF,
    parameter int HANDLES   = qmh_pkg::HANDLES_DEF,
    parameter int KEY_WIDTH = qmh_pkg::KEY_WIDTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_fire,
    input  logic [1:0]     in_func,
    input  logic [7:0]     in_handle,
    input  logic [63:0]    in_key,
    input  qmh_pkg::cmd_t  cmd,
    output qmh_pkg::sts_t  sts,
    output logic [1:0]     out_status,
    output logic [7:0]     out_handle,
    output logic [63:0]    out_key,
    output logic [8:0]     out_count
);

    localparam int SAW = $clog2(CAPACITY);
    localparam int HIW = $clog2(HANDLES);
    localparam int CNW = $clog2(CAPACITY + 1);
    localparam int FW  = SAW + 2;

    logic [7:0]           slot_h_mem [CAPACITY];
    logic [KEY_WIDTH-1:0] slot_k_mem [CAPACITY];
    logic [SAW-1:0]       pos_mem [HANDLES];
    logic                 posv_reg [HANDLES];

    logic [1:0]           func_reg;
    logic [7:0]           h_reg;
    logic [KEY_WIDTH-1:0] k_reg;
    logic [CNW-1:0]       cnt_reg, cnt_next;
    logic [SAW-1:0]       base_reg;
    logic [SAW-1:0]       hole_reg;
    logic [7:0]           mh_reg;
    logic [KEY_WIDTH-1:0] mk_reg;
    logic [SAW-1:0]       best_idx_reg;
    logic [7:0]           best_h_reg;
    logic [KEY_WIDTH-1:0] best_k_reg;
    logic [1:0]           ci_reg;
    logic [1:0]           st_reg;
    logic [7:0]           oh_reg;
    logic [KEY_WIDTH-1:0] ok_reg;
    logic [SAW-1:0]       pos_rd_reg;
    logic [7:0]           rd_h_reg;
    logic [KEY_WIDTH-1:0] rd_k_reg;
    logic [1:0]           ost_reg;
    logic [7:0]           oh_out_reg;
    logic [63:0]          ok_out_reg;
    logic [8:0]           ocnt_reg;

    logic [HIW-1:0]       hidx;
    logic                 h_in_range;
    logic [CNW-1:0]       cnt_m1;
    logic [FW-1:0]        first;
    logic [FW-1:0]        next_child;
    logic [SAW-1:0]       child_idx;
    logic [SAW-1:0]       parent;
    logic [SAW-1:0]       rd_addr;
    logic                 w_en;
    logic [SAW-1:0]       w_addr;
    logic [7:0]           w_h;
    logic [KEY_WIDTH-1:0] w_k;
    logic                 better;

    assign hidx       = HIW'(h_reg);
    assign h_in_range = 32'(h_reg) < HANDLES;
    assign cnt_m1     = cnt_reg - CNW'(1);
    assign first      = {hole_reg, 2'b01};
    assign next_child = first + FW'(ci_reg) + FW'(1);
    assign child_idx  = SAW'(first + FW'(ci_reg));
    assign parent     = SAW'((hole_reg - SAW'(1)) >> 2);
    assign better     = (ci_reg == 2'd0) || (rd_k_reg < best_k_reg);

    always_comb
    begin
        sts.func      = func_reg;
        sts.h_oor     = !h_in_range;
        sts.present   = h_in_range && posv_reg[hidx] && (CNW'(pos_rd_reg) < cnt_reg);
        sts.empty     = cnt_reg == '0;
        sts.full      = cnt_reg >= CNW'(CAPACITY);
        sts.cnt_gt1   = cnt_reg > CNW'(1);
        sts.pos_last  = CNW'(pos_rd_reg) == cnt_m1;
        sts.hole_zero = hole_reg == '0;
        sts.par_less  = mk_reg < rd_k_reg;
        sts.first_ge  = 32'(first) >= 32'(cnt_reg);
        sts.scan_more = (ci_reg != 2'd3) && (32'(next_child) < 32'(cnt_reg));
        sts.best_less = best_k_reg < mk_reg;
    end

    always_comb
    begin
        case (cmd.rsel)
            qmh_pkg::RD_BASE:   rd_addr = base_reg;
            qmh_pkg::RD_LAST:   rd_addr = SAW'(cnt_m1);
            qmh_pkg::RD_PARENT: rd_addr = parent;
            qmh_pkg::RD_CHILD0: rd_addr = SAW'(first);
            qmh_pkg::RD_NEXT:   rd_addr = SAW'(next_child);
            default:            rd_addr = '0;
        endcase
    end

    always_comb
    begin
        w_en   = 1'b1;
        w_addr = hole_reg;
        w_h    = mh_reg;
        w_k    = mk_reg;
        case (cmd.wsel)
            qmh_pkg::W_IN_POS:
            begin
                w_addr = pos_rd_reg;
                w_h    = h_reg;
                w_k    = k_reg;
            end
            qmh_pkg::W_IN_CNT:
            begin
                w_addr = SAW'(cnt_reg);
                w_h    = h_reg;
                w_k    = k_reg;
            end
            qmh_pkg::W_RD_BASE:
            begin
                w_addr = base_reg;
                w_h    = rd_h_reg;
                w_k    = rd_k_reg;
            end
            qmh_pkg::W_RD_HOLE:
            begin
                w_h = rd_h_reg;
                w_k = rd_k_reg;
            end
            qmh_pkg::W_MV_HOLE:
            begin
                w_h = mh_reg;
                w_k = mk_reg;
            end
            qmh_pkg::W_BEST_HOLE:
            begin
                w_h = best_h_reg;
                w_k = best_k_reg;
            end
            default: w_en = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (w_en)
        begin
            slot_h_mem[w_addr] <= w_h;
            slot_k_mem[w_addr] <= w_k;
        end
        rd_h_reg <= slot_h_mem[rd_addr];
        rd_k_reg <= slot_k_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (w_en && (32'(w_h) < HANDLES))
            pos_mem[HIW'(w_h)] <= w_addr;
        pos_rd_reg <= pos_mem[hidx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HANDLES; i++)
                posv_reg[i] <= 1'b0;
        end
        else
        begin
            if (cmd.clr == qmh_pkg::CLR_IN && h_in_range)
                posv_reg[hidx] <= 1'b0;
            if (cmd.clr == qmh_pkg::CLR_RD && (32'(rd_h_reg) < HANDLES))
                posv_reg[HIW'(rd_h_reg)] <= 1'b0;
            if (w_en && (32'(w_h) < HANDLES))
                posv_reg[HIW'(w_h)] <= 1'b1;
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.cnt_inc)
            cnt_next = cnt_reg + CNW'(1);
        else if (cmd.cnt_dec)
            cnt_next = cnt_m1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            func_reg <= in_func;
            h_reg    <= in_handle;
            k_reg    <= KEY_WIDTH'(in_key);
            st_reg   <= qmh_pkg::ST_OK;
            oh_reg   <= '0;
            ok_reg   <= '0;
        end
        if (cmd.set_st)
            st_reg <= cmd.st;
        if (cmd.res_root)
        begin
            oh_reg <= rd_h_reg;
            ok_reg <= rd_k_reg;
        end
        case (cmd.base_sel)
            qmh_pkg::BASE_POS:  base_reg <= pos_rd_reg;
            qmh_pkg::BASE_CNT:  base_reg <= SAW'(cnt_reg);
            qmh_pkg::BASE_ZERO: base_reg <= '0;
            default:            base_reg <= base_reg;
        endcase
        if (cmd.mv_load)
        begin
            mh_reg   <= rd_h_reg;
            mk_reg   <= rd_k_reg;
            hole_reg <= base_reg;
        end
        else if (cmd.hole_par)
            hole_reg <= parent;
        else if (cmd.hole_best)
            hole_reg <= best_idx_reg;
        if (cmd.scan_start)
            ci_reg <= 2'd0;
        if (cmd.scan_step)
        begin
            ci_reg <= ci_reg + 2'd1;
            if (better)
            begin
                best_idx_reg <= child_idx;
                best_h_reg   <= rd_h_reg;
                best_k_reg   <= rd_k_reg;
            end
        end
        if (cmd.commit)
        begin
            ost_reg    <= st_reg;
            oh_out_reg <= oh_reg;
            ok_out_reg <= 64'(ok_reg);
            ocnt_reg   <= 9'(cnt_reg);
        end
    end

    assign out_status = ost_reg;
    assign out_handle = oh_out_reg;
    assign out_key    = ok_out_reg;
    assign out_count  = ocnt_reg;

endmodule

### hdl/qmh_ctrl.sv
// Heap controller: state machine sequencing lookup, sift-up and sift-down.
// Depends on qmh_pkg and the assertion macro header.
`include "quaternary_min_heap_with_handles_defines.svh"

module qmh_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_fire,
    input  logic           out_ready,
    input  qmh_pkg::sts_t  sts,
    output logic           in_ready,
    output logic           out_valid,
    output qmh_pkg::cmd_t  cmd
);

    qmh_pkg::state_t state_reg, state_next;
    logic            down_reg, down_next;
    logic            out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= qmh_pkg::S_IDLE;
            down_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            down_reg      <= down_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        down_next  = down_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            qmh_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_fire)
                    state_next = qmh_pkg::S_LOOKUP;
            end
            qmh_pkg::S_LOOKUP:
            begin
                cmd.rsel   = qmh_pkg::RD_ZERO;
                state_next = qmh_pkg::S_CHK;
            end
            qmh_pkg::S_CHK:
            begin
                state_next = qmh_pkg::S_FINISH;
                if (sts.func == qmh_pkg::FN_INSERT)
                begin
                    if (sts.present)
                    begin
                        cmd.wsel     = qmh_pkg::W_IN_POS;
                        cmd.base_sel = qmh_pkg::BASE_POS;
                        down_next    = 1'b1;
                        state_next   = qmh_pkg::S_SU_LOAD;
                    end
                    else if (sts.h_oor)
                    begin
                        cmd.set_st = 1'b1;
                        cmd.st     = qmh_pkg::ST_ABSENT;
                    end
                    else if (sts.full)
                    begin
                        cmd.set_st = 1'b1;
                        cmd.st     = qmh_pkg::ST_FULL;
                    end
                    else
                    begin
                        cmd.wsel     = qmh_pkg::W_IN_CNT;
                        cmd.base_sel = qmh_pkg::BASE_CNT;
                        cmd.cnt_inc  = 1'b1;
                        down_next    = 1'b0;
                        state_next   = qmh_pkg::S_SU_LOAD;
                    end
                end
                else if (sts.func == qmh_pkg::FN_DELETE)
                begin
                    if (!sts.present)
                    begin
                        cmd.set_st = 1'b1;
                        cmd.st     = qmh_pkg::ST_ABSENT;
                    end
                    else
                    begin
                        cmd.clr      = qmh_pkg::CLR_IN;
                        cmd.base_sel = qmh_pkg::BASE_POS;
                        cmd.cnt_dec  = 1'b1;
                        down_next    = 1'b1;
                        if (!sts.pos_last)
                        begin
                            cmd.rsel   = qmh_pkg::RD_LAST;
                            state_next = qmh_pkg::S_MOVE;
                        end
                    end
                end
                else
                begin
                    if (sts.empty)
                    begin
                        cmd.set_st = 1'b1;
                        cmd.st     = qmh_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        cmd.res_root = 1'b1;
                        if (sts.func == qmh_pkg::FN_EXTRACT)
                        begin
                            cmd.clr      = qmh_pkg::CLR_RD;
                            cmd.cnt_dec  = 1'b1;
                            cmd.base_sel = qmh_pkg::BASE_ZERO;
                            if (sts.cnt_gt1)
                            begin
                                cmd.rsel   = qmh_pkg::RD_LAST;
                                state_next = qmh_pkg::S_MOVE;
                            end
                        end
                    end
                end
            end
            qmh_pkg::S_MOVE:
            begin
                cmd.wsel = qmh_pkg::W_RD_BASE;
                if (sts.func == qmh_pkg::FN_EXTRACT)
                    state_next = qmh_pkg::S_SD_LOAD;
                else
                    state_next = qmh_pkg::S_SU_LOAD;
            end
            qmh_pkg::S_SU_LOAD:
            begin
                cmd.rsel   = qmh_pkg::RD_BASE;
                state_next = qmh_pkg::S_SU_LATCH;
            end
            qmh_pkg::S_SU_LATCH:
            begin
                cmd.mv_load = 1'b1;
                state_next  = qmh_pkg::S_SU_CHK;
            end
            qmh_pkg::S_SU_CHK:
            begin
                if (sts.hole_zero)
                begin
                    cmd.wsel   = qmh_pkg::W_MV_HOLE;
                    state_next = down_reg ? qmh_pkg::S_SD_LOAD : qmh_pkg::S_FINISH;
                end
                else
                begin
                    cmd.rsel   = qmh_pkg::RD_PARENT;
                    state_next = qmh_pkg::S_SU_CMP;
                end
            end
            qmh_pkg::S_SU_CMP:
            begin
                if (sts.par_less)
                begin
                    cmd.wsel     = qmh_pkg::W_RD_HOLE;
                    cmd.hole_par = 1'b1;
                    state_next   = qmh_pkg::S_SU_CHK;
                end
                else
                begin
                    cmd.wsel   = qmh_pkg::W_MV_HOLE;
                    state_next = down_reg ? qmh_pkg::S_SD_LOAD : qmh_pkg::S_FINISH;
                end
            end
            qmh_pkg::S_SD_LOAD:
            begin
                cmd.rsel   = qmh_pkg::RD_BASE;
                state_next = qmh_pkg::S_SD_LATCH;
            end
            qmh_pkg::S_SD_LATCH:
            begin
                cmd.mv_load = 1'b1;
                state_next  = qmh_pkg::S_SD_CHK;
            end
            qmh_pkg::S_SD_CHK:
            begin
                if (sts.first_ge)
                begin
                    cmd.wsel   = qmh_pkg::W_MV_HOLE;
                    state_next = qmh_pkg::S_FINISH;
                end
                else
                begin
                    cmd.rsel       = qmh_pkg::RD_CHILD0;
                    cmd.scan_start = 1'b1;
                    state_next     = qmh_pkg::S_SD_SCAN;
                end
            end
            qmh_pkg::S_SD_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_more)
                    cmd.rsel = qmh_pkg::RD_NEXT;
                else
                    state_next = qmh_pkg::S_SD_DEC;
            end
            qmh_pkg::S_SD_DEC:
            begin
                if (sts.best_less)
                begin
                    cmd.wsel      = qmh_pkg::W_BEST_HOLE;
                    cmd.hole_best = 1'b1;
                    state_next    = qmh_pkg::S_SD_CHK;
                end
                else
                begin
                    cmd.wsel   = qmh_pkg::W_MV_HOLE;
                    state_next = qmh_pkg::S_FINISH;
                end
            end
            qmh_pkg::S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.commit = 1'b1;
                    state_next = qmh_pkg::S_IDLE;
                end
            end
            default: state_next = qmh_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
            out_valid_next = 1'b1;
        else if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
    end

    assign out_valid = out_valid_reg;

    `QMH_ASSERT_IMPL(a_commit_free, clk, rst_n, cmd.commit, !out_valid_reg || out_ready, "result overwritten")
    `QMH_ASSERT_NEXT(a_commit_valid, clk, rst_n, cmd.commit, out_valid_reg, "committed result not shown")
    `QMH_ASSERT_NEXT(a_accept_lookup, clk, rst_n, in_fire, state_reg == qmh_pkg::S_LOOKUP, "accept lost")

endmodule

### hdl/quaternary_min_heap_with_handles.sv
// Top level of the addressable 4-ary min-heap.
// Depends on qmh_pkg, qmh_if, qmh_ctrl and qmh_datapath.
//
// Usage:
//   req carries one operation per beat: func (insert/update, extract, delete,
//   peek), handle and key. rsp returns one beat per request: status,
//   out_handle, out_key and the entry count after the operation.
// Operation:
//   One request is worked on at a time. Peek and error cases finish right
//   after the lookup; insert climbs level by level, extract descends level
//   by level, each level reading up to four children through the single
//   slot-memory read port; update runs both phases, and so does delete
//   unless it removes the last entry. The next request can be taken in the
//   cycle after the response is loaded.
// Reset:
//   The heap is empty after reset; handle presence bits clear at once, so
//   requests are taken on the first cycle after reset.
// Stall:
//   The response sits in an output register; the next request is accepted
//   and processed while it waits, and that one stalls at completion until
//   rsp is taken.
module quaternary_min_heap_with_handles #(
    parameter int CAPACITY  = qmh_pkg::CAPACITY_DEF,
    parameter int HANDLES   = qmh_pkg::HANDLES_DEF,
    parameter int KEY_WIDTH = qmh_pkg::KEY_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    qmh_req_if.sink     req,
    qmh_rsp_if.source   rsp
);

    qmh_pkg::cmd_t cmd;
    qmh_pkg::sts_t sts;
    logic          in_ready;
    logic          in_fire;

    assign req.ready = in_ready;
    assign in_fire   = req.valid && in_ready;

    qmh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .out_ready (rsp.ready),
        .sts       (sts),
        .in_ready  (in_ready),
        .out_valid (rsp.valid),
        .cmd       (cmd)
    );

    qmh_datapath #(
        .CAPACITY  (CAPACITY),
        .HANDLES   (HANDLES),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_fire    (in_fire),
        .in_func    (req.func),
        .in_handle  (req.handle),
        .in_key     (req.key),
        .cmd        (cmd),
        .sts        (sts),
        .out_status (rsp.status),
        .out_handle (rsp.out_handle),
        .out_key    (rsp.out_key),
        .out_count  (rsp.count)
    );

endmodule
